[src/sdf_pkg.sv]
// ----------------------------------------------------------------------------
// sdf_pkg: shared definitions for the stable duplicate filter
// Field widths of the data path and the default table size.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

	// Width of one data word on the value path.
	localparam int unsigned DATA_W = 32;

	// Width of the reported unique count.
	localparam int unsigned COUNT_OUT_W = 9;

	// Default number of table entries.
	localparam int unsigned TABLE_ENTRIES_DEF = 256;

	typedef logic signed [DATA_W-1:0] data_t;

endpackage

`default_nettype wire

[src/sdf_ram.sv]
// ----------------------------------------------------------------------------
// sdf_ram: generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[src/stable_duplicate_filter_top.sv]
// ----------------------------------------------------------------------------
// stable_duplicate_filter_top: order-preserving duplicate removal
// Searches each word against a table of distinct words of the current set
// and appends it when it is new.
// ----------------------------------------------------------------------------
// Search: the single read port scans the stored entries in order, one entry
// per cycle; the search ends on the first hit, after the last entry on a
// miss, or without any read on an empty table, and the result is then strobed.
// A new word is taken only while idle, so only after the result of the last one;
// busy drops with the result strobe and the receiver cannot stall.
// Reset clears the fill count, control state and outputs, not the table.
`default_nettype none

module stable_duplicate_filter_top #(
	parameter int unsigned TABLE_ENTRIES = sdf_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [sdf_pkg::DATA_W-1:0]     value,
	input  wire logic                                  last_of_set,
	output logic                                       done,
	output logic signed [sdf_pkg::DATA_W-1:0]          echo_value,
	output logic                                       is_new,
	output logic [sdf_pkg::COUNT_OUT_W-1:0]            unique_count,
	output logic                                       overflow,
	output logic                                       end_of_set
);

	import sdf_pkg::*;

	localparam int unsigned AW    = $clog2(TABLE_ENTRIES);
	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic               rd_vld_s1;
	data_t              value_q;
	logic               last_q;

	logic               rd_en;
	logic [DATA_W-1:0]  rd_data;
	logic               hit;
	logic               scan_end;
	logic               finish;
	logic               store;
	logic [CNT_W-1:0]   count_next;
	logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

	// Table of distinct words seen in the current set.
	sdf_ram #(
		.WIDTH(DATA_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (store),
		.waddr(count_q[AW-1:0]),
		.wdata(value_q),
		.re   (rd_en),
		.raddr(idx_q[AW-1:0]),
		.rdata(rd_data)
	);

	// Search control: one read issued per cycle, each compared in the cycle after.
	assign hit      = rd_vld_s1 && (rd_data == value_q);
	assign scan_end = (idx_q == count_q) && !rd_vld_s1;
	assign finish   = (state_q == ST_SEARCH) && (hit || scan_end);
	assign rd_en    = (state_q == ST_SEARCH) && !finish && (idx_q != count_q);

	// A miss appends the word while there is room.
	assign store      = finish && !hit && (count_q < CNT_FULL);
	assign count_next = store ? count_q + CNT_W'(1) : count_q;
	assign count_ext  = {{COUNT_OUT_W{1'b0}}, count_next};

	assign busy = (state_q != ST_IDLE);

	// State, fill count and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			value_q      <= '0;
			last_q       <= 1'b0;
			done         <= 1'b0;
			echo_value   <= '0;
			is_new       <= 1'b0;
			overflow     <= 1'b0;
			unique_count <= '0;
			end_of_set   <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (start) begin
						value_q <= value;
						last_q  <= last_of_set;
						idx_q   <= '0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (finish) begin
						rd_vld_s1    <= 1'b0;
						done         <= 1'b1;
						echo_value   <= value_q;
						is_new       <= !hit;
						overflow     <= !hit && !store;
						unique_count <= count_ext[COUNT_OUT_W-1:0];
						end_of_set   <= last_q;
						count_q      <= last_q ? '0 : count_next;
						state_q      <= ST_IDLE;
					end else begin
						rd_vld_s1 <= rd_en;
						if (rd_en) begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// The fill count never passes the table size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("fill count beyond table size");

	// The read pointer never runs past the fill count.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (idx_q <= count_q))
		else $error("search pointer beyond fill count");

	// A result is only presented once the block has gone idle again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An overflow is only reported for a new word on a full table.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (is_new && $past(count_q) == CNT_FULL))
		else $error("overflow without full table");

	// No read data is left pending once the search has ended.
	a_rd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rd_vld_s1 || $past(state_q) == ST_SEARCH)
		else $error("stale read in idle");
`endif

endmodule

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench for stable_duplicate_filter_top
// Streams sets of signed words into the filter. Sets are mostly short and
// repetitive, and one set fills the whole table and then overflows it. A
// scoreboard keeps its own table of the distinct words in the current set
// and checks every result word against the oldest outstanding verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sdf_pkg::*;

	localparam int unsigned SLOTS = TABLE_ENTRIES_DEF;
	localparam int unsigned TARGET_WORDS = 600;

	typedef struct {
		data_t                  echo;
		logic                   fresh;
		logic [COUNT_OUT_W-1:0] count;
		logic                   spill;
		logic                   closing;
	} verdict_t;

	// Scoreboard: mirrors the filter's table and queues one verdict per word.
	class dedup_scoreboard;
		logic [DATA_W-1:0] seen [SLOTS];
		int unsigned       fill;
		verdict_t          pending_verdicts[$];
		int unsigned       mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		function int unsigned outstanding();
			return pending_verdicts.size();
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		// Classify an accepted word and update the mirrored table.
		function void note_word(data_t word, logic last);
			verdict_t    v;
			logic        found;
			int unsigned i;
			found = 1'b0;
			for (i = 0; i < fill; i++) begin
				if (seen[i] == word)
					found = 1'b1;
			end
			v.echo = word;
			v.fresh = !found;
			v.spill = 1'b0;
			if (!found) begin
				if (fill < SLOTS) begin
					seen[fill] = word;
					fill++;
				end else begin
					v.spill = 1'b1;
				end
			end
			v.count = COUNT_OUT_W'(fill);
			v.closing = last;
			pending_verdicts.push_back(v);
			// The result reports the count before the table is emptied.
			if (last)
				fill = 0;
		endfunction

		task check_verdict(data_t echo, logic fresh, logic [COUNT_OUT_W-1:0] count,
				logic spill, logic closing);
			verdict_t exp;
			if (pending_verdicts.size() == 0) begin
				report($sformatf("result word %0d with no word outstanding", echo));
				return;
			end
			exp = pending_verdicts.pop_front();
			if (echo !== exp.echo)
				report($sformatf("echo_value %0d, expected %0d", echo, exp.echo));
			if (fresh !== exp.fresh)
				report($sformatf("is_new %b, expected %b for word %0d",
					fresh, exp.fresh, exp.echo));
			if (count !== exp.count)
				report($sformatf("unique_count %0d, expected %0d for word %0d",
					count, exp.count, exp.echo));
			if (spill !== exp.spill)
				report($sformatf("overflow %b, expected %b for word %0d",
					spill, exp.spill, exp.echo));
			if (closing !== exp.closing)
				report($sformatf("end_of_set %b, expected %b for word %0d",
					closing, exp.closing, exp.echo));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	data_t                  value;
	logic                   last_of_set;
	logic                   done;
	data_t                  echo_value;
	logic                   is_new;
	logic [COUNT_OUT_W-1:0] unique_count;
	logic                   overflow;
	logic                   end_of_set;

	dedup_scoreboard sb = new();
	int unsigned     burst_left = 0;
	int unsigned     words_sent = 0;

	stable_duplicate_filter_top #(
		.TABLE_ENTRIES(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.last_of_set(last_of_set),
		.done(done),
		.echo_value(echo_value),
		.is_new(is_new),
		.unique_count(unique_count),
		.overflow(overflow),
		.end_of_set(end_of_set)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Monitor: check result words and note accepted words.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (done === 1'b1)
				sb.check_verdict(echo_value, is_new, unique_count, overflow, end_of_set);
			if (start === 1'b1 && busy === 1'b0)
				sb.note_word(value, last_of_set);
		end
	end

	// Present one word and hold it until the filter takes it. Between bursts
	// start drops for a random gap.
	task automatic send_word(input data_t word, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			start <= 1'b0;
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		start <= 1'b1;
		value <= word;
		last_of_set <= last;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		burst_left--;
		words_sent++;
	endtask

	// Random word, biased a little towards the extremes and small values.
	function automatic data_t pick_value();
		case ($urandom_range(0, 9))
			0: return data_t'(32'h8000_0000);
			1: return data_t'(32'h7FFF_FFFF);
			2: return data_t'($urandom_range(0, 7)) - data_t'(4);
			default: return data_t'($urandom);
		endcase
	endfunction

	// One set whose words come mostly from a small pool, so duplicates abound.
	task automatic random_set();
		data_t       pool[$];
		int unsigned len;
		int unsigned n_pool;
		int unsigned k;
		data_t       w;
		len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
		n_pool = $urandom_range(1, 12);
		for (k = 0; k < n_pool; k++)
			pool.push_back(pick_value());
		for (k = 0; k < len; k++) begin
			w = ($urandom_range(0, 4) == 0) ? pick_value() : pool[$urandom_range(0, n_pool - 1)];
			send_word(w, k == len - 1);
		end
	endtask

	// One set that fills every slot and then offers further new words, which
	// must be flagged as overflowing each time they appear.
	task automatic fill_whole_table();
		data_t       kept[$];
		data_t       spills[$];
		logic [31:0] r;
		int unsigned i;
		for (i = 0; i < SLOTS; i++) begin
			r = $urandom;
			r[8:0] = 9'(i);
			send_word(data_t'(r), 1'b0);
			kept.push_back(data_t'(r));
			if ($urandom_range(0, 9) == 0)
				send_word(kept[$urandom_range(0, kept.size() - 1)], 1'b0);
		end
		for (i = 0; i < 6; i++) begin
			r = $urandom;
			r[8:0] = 9'(SLOTS + i);
			spills.push_back(data_t'(r));
		end
		for (i = 0; i < 30; i++) begin
			case ($urandom_range(0, 2))
				0: send_word(spills[$urandom_range(0, spills.size() - 1)], 1'b0);
				1: send_word(kept[$urandom_range(0, kept.size() - 1)], 1'b0);
				default: send_word(pick_value(), 1'b0);
			endcase
		end
		send_word(spills[0], 1'b1);
		// After the clear, a formerly stored word counts as new again.
		send_word(kept[0], 1'b0);
		send_word(kept[0], 1'b1);
	endtask

	// Stimulus.
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		last_of_set = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes, duplicates of each, and a duplicate closing the set.
		send_word(data_t'(32'h8000_0000), 1'b0);
		send_word(data_t'(32'h7FFF_FFFF), 1'b0);
		send_word(data_t'(0), 1'b0);
		send_word(data_t'(-1), 1'b0);
		send_word(data_t'(32'h8000_0000), 1'b0);
		send_word(data_t'(1), 1'b0);
		send_word(data_t'(-1), 1'b0);
		send_word(data_t'(32'h7FFF_FFFF), 1'b1);
		// A single-word set right after a clear.
		send_word(data_t'(32'h8000_0000), 1'b1);
		// Alternating bit patterns and a run of one word.
		send_word(data_t'(32'h5555_5555), 1'b0);
		send_word(data_t'(32'hAAAA_AAAA), 1'b0);
		send_word(data_t'(5), 1'b0);
		send_word(data_t'(5), 1'b0);
		send_word(data_t'(32'h5555_5555), 1'b0);
		send_word(data_t'(5), 1'b1);
		// A new word closing its set.
		send_word(data_t'(0), 1'b0);
		send_word(data_t'(-2), 1'b1);

		// Random part: one full-table set among many short ones.
		repeat (3) random_set();
		fill_whole_table();
		while (words_sent < TARGET_WORDS)
			random_set();
		start <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SLOTS + 20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog.
	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
src/sdf_pkg.sv
src/sdf_ram.sv
src/stable_duplicate_filter_top.sv
dv/tb.sv
